// ===== rtl/nbgfs_pkg.sv =====
// shared types and constants for the gravity force summer
package nbgfs_pkg;
   localparam int unsigned CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAV_CONST    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAP_LIMIT = 8'd1;
   localparam logic [31:0] GRAV_CONST_RST    = 32'd65536;
   localparam logic [31:0] OVERLAP_LIMIT_RST = 32'd131072;
   localparam logic signed [47:0] SAT_POS = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] SAT_NEG = 48'sh8000_0000_0000;
   localparam logic [47:0] CAP_MAG = 48'h8000_0000_0000;
   typedef logic signed [47:0] force_type;

   // add a term to a running sum and clamp to the 48-bit range
   function automatic force_type sat_add(input force_type a, input force_type b);
      logic signed [48:0] s;
      begin
         s = {a[47], a} + {b[47], b};
         if (s > 49'sh0_7FFF_FFFF_FFFF) sat_add = SAT_POS;
         else if (s < -49'sh0_8000_0000_0000) sat_add = SAT_NEG;
         else sat_add = s[47:0];
      end
   endfunction
endpackage

// ===== rtl/nbgfs_pair.sv =====
// pair force unit: isqrt, limb products, long division, one step per cycle
module nbgfs_pair (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic signed [32:0]    dx,
   input  logic signed [32:0]    dy,
   input  logic [31:0]           gc,
   input  logic [31:0]           mi,
   input  logic [31:0]           mj,
   input  logic [31:0]           olim,
   output logic                  done,
   output nbgfs_pkg::force_type  tx,
   output nbgfs_pkg::force_type  ty
);
   localparam logic [3:0] P_IDLE = 4'd0, P_SQ = 4'd1, P_SQ2 = 4'd2, P_ROOT = 4'd3,
                          P_GM = 4'd4, P_GM2 = 4'd5, P_R3 = 4'd6, P_R3B = 4'd7,
                          P_NUM = 4'd8, P_DIV = 4'd9, P_OUT = 4'd10;
   logic [3:0]   st_ff, st_in;
   logic [32:0]  ax_ff, ay_ff;
   logic         sx_ff, sy_ff, zx_ff, zy_ff;
   logic [66:0]  s_ff;
   logic [33:0]  q_ff;
   logic [5:0]   b_ff;
   logic [63:0]  gm_ff;
   logic [95:0]  gmm_ff;
   logic [101:0] r3_ff;
   logic [159:0] nx_ff, ny_ff;
   logic [101:0] rx_ff, ry_ff;
   logic [47:0]  qx_ff, qy_ff;
   logic         vx_ff, vy_ff;
   logic [7:0]   k_ff;
   logic [1:0]   c_ff;
   logic [33:0]  t;
   logic [67:0]  tsq;
   logic [102:0] remx, remy;
   logic [47:0]  mx, my;
   logic [65:0]  sqx, sqy;
   logic [63:0]  gmh, gml;
   logic [67:0]  qsq, r3h, r3l;
   logic [64:0]  nxp, nyp;

   assign t   = q_ff | (34'd1 << b_ff);
   assign tsq = t * t;
   assign remx = {rx_ff, nx_ff[k_ff]};
   assign remy = {ry_ff, ny_ff[k_ff]};
   assign sqx = ax_ff * ax_ff;
   assign sqy = ay_ff * ay_ff;
   assign gmh = gm_ff[63:32] * mj;
   assign gml = gm_ff[31:0] * mj;
   assign qsq = q_ff * q_ff;
   assign r3h = r3_ff[67:34] * q_ff;
   assign r3l = r3_ff[33:0] * q_ff;
   assign nxp = gmm_ff[c_ff*32 +: 32] * ax_ff;
   assign nyp = gmm_ff[c_ff*32 +: 32] * ay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= P_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         P_IDLE: if (go) st_in = P_SQ;
         P_SQ:   st_in = P_SQ2;
         P_SQ2:  st_in = P_ROOT;
         P_ROOT: if (b_ff == 6'd0) st_in = P_GM;
         P_GM:   st_in = (q_ff > {2'b0, olim}) ? P_GM2 : P_OUT;
         P_GM2:  st_in = P_R3;
         P_R3:   st_in = P_R3B;
         P_R3B:  st_in = P_NUM;
         P_NUM:  if (c_ff == 2'd2) st_in = P_DIV;
         P_DIV:  if (k_ff == 8'd0) st_in = P_OUT;
         P_OUT:  st_in = P_IDLE;
         default: st_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         P_IDLE: begin
            sx_ff <= ~dx[32]; sy_ff <= ~dy[32];
            zx_ff <= (dx == 33'sd0); zy_ff <= (dy == 33'sd0);
            ax_ff <= dx[32] ? 33'(-dx) : 33'(dx);
            ay_ff <= dy[32] ? 33'(-dy) : 33'(dy);
            q_ff <= '0; b_ff <= 6'd33; vx_ff <= 1'b0; vy_ff <= 1'b0;
            qx_ff <= '0; qy_ff <= '0;
         end
         P_SQ:  s_ff <= {1'b0, sqx};
         P_SQ2: s_ff <= s_ff + {1'b0, sqy};
         P_ROOT: begin
            if (tsq <= {1'b0, s_ff}) q_ff <= t;
            if (b_ff != 6'd0) b_ff <= b_ff - 6'd1;
         end
         P_GM:  gm_ff <= gc * mi;
         P_GM2: gmm_ff <= {gmh, 32'd0} + {32'd0, gml};
         P_R3:  r3_ff <= {34'd0, qsq};
         P_R3B: begin
            r3_ff <= {r3h, 34'd0} + {34'd0, r3l};
            c_ff <= 2'd0; nx_ff <= '0; ny_ff <= '0;
         end
         P_NUM: begin
            nx_ff <= nx_ff + (160'(nxp) << (c_ff*32 + 8));
            ny_ff <= ny_ff + (160'(nyp) << (c_ff*32 + 8));
            c_ff <= c_ff + 2'd1;
            rx_ff <= '0; ry_ff <= '0; k_ff <= 8'd159;
         end
         P_DIV: begin
            if (remx >= {1'b0, r3_ff}) begin
               rx_ff <= 102'(remx - {1'b0, r3_ff});
               if (k_ff >= 8'd47) vx_ff <= 1'b1; else qx_ff[k_ff[5:0]] <= 1'b1;
            end else rx_ff <= remx[101:0];
            if (remy >= {1'b0, r3_ff}) begin
               ry_ff <= 102'(remy - {1'b0, r3_ff});
               if (k_ff >= 8'd47) vy_ff <= 1'b1; else qy_ff[k_ff[5:0]] <= 1'b1;
            end else ry_ff <= remy[101:0];
            if (k_ff != 8'd0) k_ff <= k_ff - 8'd1;
         end
         default: ;
      endcase
   end

   assign mx = vx_ff ? nbgfs_pkg::CAP_MAG : qx_ff;
   assign my = vy_ff ? nbgfs_pkg::CAP_MAG : qy_ff;
   // positive d pushes negative; cap of 2^47 as positive clamps to max
   assign tx = zx_ff ? '0 : (sx_ff ? (vx_ff ? nbgfs_pkg::SAT_NEG : -$signed(mx))
                                  : (vx_ff ? nbgfs_pkg::SAT_POS : $signed(mx)));
   assign ty = zy_ff ? '0 : (sy_ff ? (vy_ff ? nbgfs_pkg::SAT_NEG : -$signed(my))
                                  : (vy_ff ? nbgfs_pkg::SAT_POS : $signed(my)));
   assign done = (st_ff == P_OUT);
endmodule

// ===== rtl/nbody_gravity_force_sum.sv =====
// top level of the direct-sum 2-d gravity force summer
//  channel | direction | ports                               | handshake
//  req     | in        | pos_x pos_y mass is_last            | start & !busy
//  rsp     | out       | particle_index force_x force_y final | strobe, one cycle
//  csr     | in        | index data                          | valid & ready
// loading accepts one transaction per cycle while not busy; the last one starts the pass
// an interacting pair is read, latched, run through the pair unit and summed;
// a pair at or under the overlap limit skips products and division; a particle with
// itself skips the pair unit; each particle adds an index read, end check and result
// reset is synchronous; busy is high for the whole pass; the receiver cannot stall
module nbody_gravity_force_sum #(
   parameter int unsigned MAX_PARTICLES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [31:0]              req_pos_x,
   input  logic signed [31:0]              req_pos_y,
   input  logic [31:0]                     req_mass,
   input  logic                            req_is_last,
   output logic                            rsp_strobe,
   output logic [5:0]                      rsp_particle_index,
   output logic signed [47:0]              rsp_force_x,
   output logic signed [47:0]              rsp_force_y,
   output logic                            rsp_is_final,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nbgfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                     csr_data
);
   localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
   localparam logic [2:0] S_LOAD = 3'd0, S_RDI = 3'd1, S_RDJ = 3'd2, S_LAT = 3'd3,
                          S_PAIR = 3'd4, S_NEXT = 3'd5, S_EMIT = 3'd6;

   logic [31:0] x_mem [MAX_PARTICLES];
   logic [31:0] y_mem [MAX_PARTICLES];
   logic [31:0] m_mem [MAX_PARTICLES];
   logic [31:0] rx_ff, ry_ff, rm_ff, xi_ff, yi_ff, mi_ff;
   logic [AW-1:0] ra;
   logic [2:0]  st_ff, st_in;
   logic [CW-1:0] cnt_ff, i_ff, j_ff;
   logic [31:0] gc_ff, ol_ff;
   nbgfs_pkg::force_type fx_ff, fy_ff, tx, ty;
   logic        go, done, accept, lat_i_ff;

   assign accept = start && !busy;
   assign busy = (st_ff != S_LOAD);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gc_ff <= nbgfs_pkg::GRAV_CONST_RST;
         ol_ff <= nbgfs_pkg::OVERLAP_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            nbgfs_pkg::CSR_GRAV_CONST:    gc_ff <= csr_data;
            nbgfs_pkg::CSR_OVERLAP_LIMIT: ol_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign ra = (st_ff == S_RDI) ? i_ff[AW-1:0] : j_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (accept && cnt_ff < CW'(MAX_PARTICLES)) begin
         x_mem[cnt_ff[AW-1:0]] <= req_pos_x;
         y_mem[cnt_ff[AW-1:0]] <= req_pos_y;
         m_mem[cnt_ff[AW-1:0]] <= req_mass;
      end
      rx_ff <= x_mem[ra];
      ry_ff <= y_mem[ra];
      rm_ff <= m_mem[ra];
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_LOAD: if (accept && req_is_last) st_in = S_RDI;
         S_RDI:  st_in = S_RDJ;
         S_RDJ:  st_in = (j_ff >= cnt_ff) ? S_EMIT : (j_ff == i_ff) ? S_NEXT : S_LAT;
         S_LAT:  st_in = S_PAIR;
         S_PAIR: if (done) st_in = S_NEXT;
         S_NEXT: st_in = S_RDJ;
         S_EMIT: st_in = (i_ff + CW'(1) >= cnt_ff) ? S_LOAD : S_RDI;
         default: st_in = S_LOAD;
      endcase
   end

   assign go = (st_ff == S_LAT);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD;
         cnt_ff <= '0;
         lat_i_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         lat_i_ff <= (st_ff == S_RDI);
         unique case (st_ff)
            S_LOAD: begin
               if (accept && cnt_ff < CW'(MAX_PARTICLES)) cnt_ff <= cnt_ff + CW'(1);
               i_ff <= '0;
            end
            S_RDI: begin
               j_ff <= '0; fx_ff <= '0; fy_ff <= '0;
            end
            S_PAIR: if (done) begin
               fx_ff <= nbgfs_pkg::sat_add(fx_ff, tx);
               fy_ff <= nbgfs_pkg::sat_add(fy_ff, ty);
            end
            S_NEXT: j_ff <= j_ff + CW'(1);
            S_EMIT: begin
               i_ff <= i_ff + CW'(1);
               if (i_ff + CW'(1) >= cnt_ff) cnt_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (lat_i_ff) begin
         xi_ff <= rx_ff; yi_ff <= ry_ff; mi_ff <= rm_ff;
      end
   end

   nbgfs_pair u_pair (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .dx    (33'(signed'(xi_ff)) - 33'(signed'(rx_ff))),
      .dy    (33'(signed'(yi_ff)) - 33'(signed'(ry_ff))),
      .gc    (gc_ff),
      .mi    (mi_ff),
      .mj    (rm_ff),
      .olim  (ol_ff),
      .done  (done),
      .tx    (tx),
      .ty    (ty)
   );

   assign rsp_strobe = (st_ff == S_EMIT);
   assign rsp_particle_index = 6'(i_ff);
   assign rsp_force_x = fx_ff;
   assign rsp_force_y = fy_ff;
   assign rsp_is_final = (i_ff + CW'(1) >= cnt_ff);
endmodule

// ===== sim/nbody_gravity_force_sum_tb.sv =====
// self-checking testbench for the direct-sum 2-d gravity force summer
`timescale 1ns / 100ps

module nbody_gravity_force_sum_tb;

   localparam int unsigned NUM_SLOTS = 64;
   localparam logic [nbgfs_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 8'hA5;
   localparam logic [159:0] MAG_CAP = 160'h1 << 47;

   typedef enum {JOB_PARTICLE, JOB_CSR, JOB_DRAIN} job_kind_type;

   typedef struct {
      job_kind_type kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [31:0] m;
      logic last;
      logic [nbgfs_pkg::CSR_IDX_W-1:0] idx;
      logic [31:0] data;
      int gap;
   } job_type;

   typedef struct {
      logic [5:0] index;
      nbgfs_pkg::force_type fx;
      nbgfs_pkg::force_type fy;
      logic final_flag;
   } force_result_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic [31:0] req_mass = '0;
   logic req_is_last = 1'b0;
   logic rsp_strobe;
   logic [5:0] rsp_particle_index;
   logic signed [47:0] rsp_force_x;
   logic signed [47:0] rsp_force_y;
   logic rsp_is_final;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [nbgfs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   job_type pending_jobs[$];
   force_result_type force_results_q[$];
   job_type cur_job;
   int error_count = 0;
   int quiet_cycles = 0;

   // predictor state
   logic [31:0] grav_reg = nbgfs_pkg::GRAV_CONST_RST;
   logic [31:0] overlap_reg = nbgfs_pkg::OVERLAP_LIMIT_RST;
   logic signed [31:0] px_mem[NUM_SLOTS];
   logic signed [31:0] py_mem[NUM_SLOTS];
   logic [31:0] pm_mem[NUM_SLOTS];
   int n_loaded = 0;

   nbody_gravity_force_sum uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_mass(req_mass),
      .req_is_last(req_is_last), .rsp_strobe(rsp_strobe),
      .rsp_particle_index(rsp_particle_index), .rsp_force_x(rsp_force_x),
      .rsp_force_y(rsp_force_y), .rsp_is_final(rsp_is_final),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [33:0] int_sqrt(input logic [159:0] s);
      logic [33:0] q;
      logic [159:0] t;
      q = '0;
      for (int b = 33; b >= 0; b--) begin
         t = 160'(q | (34'h1 << b));
         if (t * t <= s) q = t[33:0];
      end
      return q;
   endfunction

   function automatic longint clamp_force(input longint v);
      if (v > longint'(nbgfs_pkg::SAT_POS)) return longint'(nbgfs_pkg::SAT_POS);
      if (v < longint'(nbgfs_pkg::SAT_NEG)) return longint'(nbgfs_pkg::SAT_NEG);
      return v;
   endfunction

   function automatic longint axis_term(input logic [159:0] gmm, input longint d,
                                        input logic [159:0] r3);
      logic [159:0] mag;
      logic [159:0] q;
      longint m;
      mag = 160'(d < 0 ? -d : d);
      if (mag == 0) return 0;
      q = (gmm * mag * 160'd256) / r3;
      m = (q >= MAG_CAP) ? longint'(MAG_CAP) : longint'(q);
      return clamp_force(d > 0 ? -m : m);
   endfunction

   // pairwise force pass over the loaded set
   task automatic gravity_pass();
      longint fx, fy, dx, dy;
      logic [159:0] dist2, gmm, rr, r3;
      logic [33:0] r;
      force_result_type res;
      for (int i = 0; i < n_loaded; i++) begin
         fx = 0;
         fy = 0;
         for (int j = 0; j < n_loaded; j++) begin
            if (i == j) continue;
            dx = longint'(px_mem[i]) - longint'(px_mem[j]);
            dy = longint'(py_mem[i]) - longint'(py_mem[j]);
            dist2 = 160'(dx < 0 ? -dx : dx) * 160'(dx < 0 ? -dx : dx)
                  + 160'(dy < 0 ? -dy : dy) * 160'(dy < 0 ? -dy : dy);
            r = int_sqrt(dist2);
            if (r <= 34'(overlap_reg)) continue;
            gmm = 160'(grav_reg) * 160'(pm_mem[i]) * 160'(pm_mem[j]);
            rr = 160'(r);
            r3 = rr * rr * rr;
            fx = clamp_force(fx + axis_term(gmm, dx, r3));
            fy = clamp_force(fy + axis_term(gmm, dy, r3));
         end
         res.index = 6'(i);
         res.fx = nbgfs_pkg::force_type'(fx);
         res.fy = nbgfs_pkg::force_type'(fy);
         res.final_flag = (i + 1 == n_loaded);
         force_results_q.insert(force_results_q.size(), res);
      end
      n_loaded = 0;
   endtask

   task automatic load_particle(input job_type j);
      if (n_loaded < NUM_SLOTS) begin
         px_mem[n_loaded] = j.x;
         py_mem[n_loaded] = j.y;
         pm_mem[n_loaded] = j.m;
         n_loaded++;
      end
      if (j.last) gravity_pass();
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s at %0t: got %0d want %0d", what, $realtime, got, want);
      error_count++;
   endtask

   // driver
   always @(posedge clock) begin
      logic drive_start;
      logic drive_csr;
      job_type j;
      drive_start = start;
      drive_csr = csr_valid;
      if (reset) begin
         drive_start = 1'b0;
         drive_csr = 1'b0;
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= (busy || rsp_strobe) ? 0 : quiet_cycles + 1;
         if (start && !busy) begin
            load_particle(cur_job);
            drive_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == nbgfs_pkg::CSR_GRAV_CONST) grav_reg = csr_data;
            else if (csr_index == nbgfs_pkg::CSR_OVERLAP_LIMIT) overlap_reg = csr_data;
            drive_csr = 1'b0;
         end
         if (!drive_start && !drive_csr && pending_jobs.size() > 0) begin
            j = pending_jobs[0];
            if (j.gap > 0) begin
               pending_jobs[0].gap = j.gap - 1;
            end else begin
               case (j.kind)
                  JOB_PARTICLE: begin
                     req_pos_x <= j.x;
                     req_pos_y <= j.y;
                     req_mass <= j.m;
                     req_is_last <= j.last;
                     cur_job = j;
                     drive_start = 1'b1;
                     void'(pending_jobs.pop_front());
                  end
                  JOB_CSR: begin
                     if (force_results_q.size() == 0 && !busy && quiet_cycles >= 8) begin
                        csr_index <= j.idx;
                        csr_data <= j.data;
                        drive_csr = 1'b1;
                        void'(pending_jobs.pop_front());
                     end
                  end
                  default: begin
                     if (force_results_q.size() == 0) void'(pending_jobs.pop_front());
                  end
               endcase
            end
         end
      end
      start <= drive_start;
      csr_valid <= drive_csr;
   end

   // monitor
   always @(posedge clock) begin
      force_result_type want;
      if (!reset && rsp_strobe) begin
         if (force_results_q.size() == 0) begin
            report_mismatch("unexpected result index", rsp_particle_index, -1);
         end else begin
            want = force_results_q.pop_front();
            if (rsp_particle_index !== want.index)
               report_mismatch("particle_index", rsp_particle_index, want.index);
            if (rsp_force_x !== want.fx) report_mismatch("force_x", rsp_force_x, want.fx);
            if (rsp_force_y !== want.fy) report_mismatch("force_y", rsp_force_y, want.fy);
            if (rsp_is_final !== want.final_flag)
               report_mismatch("is_final", rsp_is_final, want.final_flag);
         end
      end
   end

   task automatic add_particle(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic [31:0] m, input logic last, input int gap);
      job_type j;
      j.kind = JOB_PARTICLE;
      j.x = x;
      j.y = y;
      j.m = m;
      j.last = last;
      j.gap = gap;
      pending_jobs.insert(pending_jobs.size(), j);
   endtask

   task automatic add_csr(input logic [nbgfs_pkg::CSR_IDX_W-1:0] idx, input logic [31:0] data);
      job_type j;
      j.kind = JOB_CSR;
      j.idx = idx;
      j.data = data;
      j.gap = 0;
      pending_jobs.insert(pending_jobs.size(), j);
   endtask

   task automatic add_drain();
      job_type j;
      j.kind = JOB_DRAIN;
      j.gap = 0;
      pending_jobs.insert(pending_jobs.size(), j);
   endtask

   task automatic add_random_set(input int n, input bit wide_spread, input bit burst);
      logic signed [31:0] x, y;
      logic [31:0] m;
      for (int k = 0; k < n; k++) begin
         if (wide_spread) begin
            x = $urandom;
            y = $urandom;
            m = $urandom;
         end else begin
            x = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            y = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            m = $urandom_range(32'h0000_1000, 32'h0010_0000);
         end
         add_particle(x, y, m, k == n - 1, burst ? 0 : $urandom_range(0, 18));
      end
   endtask

   function automatic logic [31:0] pick_reg_value(input logic [31:0] typical);
      case ($urandom_range(0, 4))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return typical;
      endcase
   endfunction

   initial begin
      int loaded;
      int set_no;
      int n;
      // directed sets
      add_particle(32'sh7FFF_FFFF, -32'sh8000_0000, 32'hFFFF_FFFF, 1'b1, 0);
      add_particle(0, 0, 32'hFFFF_FFFF, 1'b0, 0);
      add_particle(32'sh0003_0000, 0, 32'hFFFF_FFFF, 1'b1, 0);
      add_particle(-32'sh8000_0000, -32'sh8000_0000, 32'h1, 1'b0, 3);
      add_particle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
      add_particle(0, 0, 32'h0001_0000, 1'b0, 0);
      add_particle(32'sh0001_0000, 0, 32'h0001_0000, 1'b1, 0);
      add_particle(0, 0, 32'h0002_0000, 1'b0, 0);
      add_particle(0, 32'sh0002_0000, 32'h0002_0000, 1'b0, 0);
      add_particle(0, 32'sh0002_0001, 32'h0003_0000, 1'b0, 0);
      add_particle(32'sh0010_0000, 32'sh0010_0000, 32'h0, 1'b1, 0);
      add_csr(nbgfs_pkg::CSR_GRAV_CONST, 32'hFFFF_FFFF);
      add_csr(nbgfs_pkg::CSR_OVERLAP_LIMIT, 32'h0);
      add_particle(0, 0, 32'hFFFF_FFFF, 1'b0, 0);
      add_particle(32'sh0000_0001, 32'sh0000_0001, 32'hFFFF_FFFF, 1'b0, 0);
      add_particle(-32'sh0100_0000, 32'sh0100_0000, 32'h0001_0000, 1'b1, 0);
      add_csr(CSR_UNMAPPED, 32'h1234_5678);
      add_csr(nbgfs_pkg::CSR_GRAV_CONST, 32'h0);
      add_random_set(3, 1'b0, 1'b1);
      add_csr(nbgfs_pkg::CSR_GRAV_CONST, nbgfs_pkg::GRAV_CONST_RST);
      add_csr(nbgfs_pkg::CSR_OVERLAP_LIMIT, 32'hFFFF_FFFF);
      add_random_set(3, 1'b1, 1'b1);
      add_csr(nbgfs_pkg::CSR_OVERLAP_LIMIT, nbgfs_pkg::OVERLAP_LIMIT_RST);

      // random sets, mostly small
      loaded = 0;
      set_no = 0;
      while (loaded < 400) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
         add_random_set(n, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
         loaded += n;
         set_no++;
         if (set_no % 12 == 0) begin
            add_csr(nbgfs_pkg::CSR_GRAV_CONST,
                    pick_reg_value($urandom_range(1, 32'h0010_0000)));
            add_csr(nbgfs_pkg::CSR_OVERLAP_LIMIT,
                    pick_reg_value($urandom_range(0, 32'h0008_0000)));
         end
         if (set_no == 20) add_drain();
      end

      // store full: two extra items are dropped, the last still starts the pass
      add_csr(nbgfs_pkg::CSR_GRAV_CONST, nbgfs_pkg::GRAV_CONST_RST);
      add_csr(nbgfs_pkg::CSR_OVERLAP_LIMIT, nbgfs_pkg::OVERLAP_LIMIT_RST);
      add_random_set(NUM_SLOTS + 1, 1'b0, 1'b0);
      pending_jobs[$].last = 1'b0;
      add_particle($urandom, $urandom, $urandom, 1'b1, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_jobs.size() > 0 || force_results_q.size() > 0 || start || csr_valid)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/nbgfs_pkg.sv
rtl/nbgfs_pair.sv
rtl/nbody_gravity_force_sum.sv
sim/nbody_gravity_force_sum_tb.sv
